// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the list RTL.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_ON(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
		else $error("forbidden condition seen");

`endif

// File: hw/rtl/bdll_pkg.sv
// Shared types and codes of the bounded doubly linked list.
// No dependencies.
package bdll_pkg;

	localparam logic [2:0] KIND_APPEND  = 3'd0;
	localparam logic [2:0] KIND_PREPEND = 3'd1;
	localparam logic [2:0] KIND_REMOVE  = 3'd2;
	localparam logic [2:0] KIND_READ    = 3'd3;
	localparam logic [2:0] KIND_CLEAR   = 3'd4;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_INDEX = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_INS_LINK,
		ST_WALK,
		ST_RM_PREV,
		ST_RM_NEXT,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic val;
		logic nxt;
		logic prv;
	} node_wen_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} fs_cmd_t;

endpackage

// File: hw/rtl/bdll_node_mem.sv
// Node store: value, forward link and backward link per slot.
// Uses bdll_pkg for the field write enables.
module bdll_node_mem #(
	parameter int DEPTH = 256,
	parameter int DW    = 32,
	parameter int PW    = 9,
	parameter int SW    = 8
) (
	input  logic                clk,
	input  bdll_pkg::node_wen_t wen,
	input  logic [SW-1:0]       waddr,
	input  logic [DW-1:0]       wval,
	input  logic [PW-1:0]       wnxt,
	input  logic [PW-1:0]       wprv,
	input  logic [SW-1:0]       raddr,
	output logic [DW-1:0]       rval,
	output logic [PW-1:0]       rnxt,
	output logic [PW-1:0]       rprv
);

	logic [DW-1:0] val_mem [DEPTH];
	logic [PW-1:0] nxt_mem [DEPTH];
	logic [PW-1:0] prv_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wen.val) begin
			val_mem[waddr] <= wval;
		end
		if (wen.nxt) begin
			nxt_mem[waddr] <= wnxt;
		end
		if (wen.prv) begin
			prv_mem[waddr] <= wprv;
		end
		rval <= val_mem[raddr];
		rnxt <= nxt_mem[raddr];
		rprv <= prv_mem[raddr];
	end

endmodule

// File: hw/rtl/bdll_free_stack.sv
// Free slot stack with a fresh-slot counter behind it.
// Uses bdll_pkg for the command struct.
module bdll_free_stack #(
	parameter int DEPTH = 256,
	parameter int PW    = 9,
	parameter int SW    = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bdll_pkg::fs_cmd_t cmd,
	input  logic [SW-1:0]     push_slot,
	output logic [SW-1:0]     pop_slot
);

	logic [SW-1:0] mem [DEPTH];
	logic [PW-1:0] sp_q;
	logic [PW-1:0] fresh_q;
	logic [PW-1:0] sp_dec;
	logic          from_mem_q;
	logic [SW-1:0] fresh_slot_q;
	logic [SW-1:0] rd_q;

	assign sp_dec = sp_q - PW'(1);

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[sp_q[SW-1:0]] <= push_slot;
		end
		if (cmd.pop) begin
			rd_q <= mem[sp_dec[SW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q         <= '0;
			fresh_q      <= '0;
			from_mem_q   <= 1'b0;
			fresh_slot_q <= '0;
		end else if (cmd.clear) begin
			sp_q    <= '0;
			fresh_q <= '0;
		end else if (cmd.push) begin
			sp_q <= sp_q + PW'(1);
		end else if (cmd.pop) begin
			if (sp_q != '0) begin
				sp_q       <= sp_dec;
				from_mem_q <= 1'b1;
			end else begin
				fresh_q      <= fresh_q + PW'(1);
				fresh_slot_q <= fresh_q[SW-1:0];
				from_mem_q   <= 1'b0;
			end
		end
	end

	assign pop_slot = from_mem_q ? rd_q : fresh_slot_q;

endmodule

// File: hw/rtl/bounded_doubly_linked_list.sv
// An append or prepend passes ST_POP, then ST_INS_LINK unless the list was empty; a read
// walks to its position; a remove walks, then unlinks in ST_RM_PREV and ST_RM_NEXT; clear,
// unused kinds and full/index errors go straight to ST_RESP. One request at a time; the
// walk reads one node per cycle, and no new request is accepted until the result is
// registered. Reset clears control state only; memories are not cleared and need no
// pass. Uses bdll_pkg, bdll_node_mem, bdll_free_stack, macros.
`include "assert_macros.svh"
module bounded_doubly_linked_list #(
	parameter int CAPACITY   = 256,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // value[31:0], position[39:32]
	input  logic [2:0]  s_tuser,  // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // read_value[31:0], list_length[40:32], zero[47:41]
	output logic [1:0]  m_tuser   // status[1:0]
);

	localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int PW = $clog2(CAPACITY + 1);
	localparam logic [PW-1:0] NIL = PW'(CAPACITY);

	bdll_pkg::state_t state_q, state_d;

	logic [2:0]          kind_q;
	logic [31:0]         val_q;
	logic [7:0]          pos_q;
	logic [7:0]          cnt_q;
	logic [PW-1:0]       cur_q, prv_q, nxt_q, head_q, tail_q, count_q;
	logic [SW-1:0]       slot_q;
	logic [31:0]         res_rd_q, out_rd_q;
	logic [1:0]          res_st_q, out_st_q;
	logic [8:0]          out_len_q;
	logic                out_valid_q;

	logic                acc, is_ins, is_walk, full, empty, hit, out_free;
	bdll_pkg::node_wen_t mw_en;
	logic [SW-1:0]       mw_addr, mr_addr;
	logic [DATA_WIDTH-1:0] mw_val, mr_val;
	logic [PW-1:0]       mw_nxt, mw_prv, mr_nxt, mr_prv;
	bdll_pkg::fs_cmd_t   fs_cmd;
	logic [SW-1:0]       pop_slot;

	assign s_tready = (state_q == bdll_pkg::ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign is_ins   = (s_tuser == bdll_pkg::KIND_APPEND) || (s_tuser == bdll_pkg::KIND_PREPEND);
	assign is_walk  = (s_tuser == bdll_pkg::KIND_REMOVE) || (s_tuser == bdll_pkg::KIND_READ);
	assign full     = (count_q == NIL);
	assign empty    = (count_q == '0);
	assign hit      = (cnt_q == pos_q);
	assign out_free = !out_valid_q || m_tready;
	assign mw_val   = DATA_WIDTH'(val_q);
	assign mr_addr  = (state_q == bdll_pkg::ST_WALK) ? mr_nxt[SW-1:0] : head_q[SW-1:0];

	bdll_node_mem #(.DEPTH(CAPACITY), .DW(DATA_WIDTH), .PW(PW), .SW(SW)) u_node (
		.clk(clk), .wen(mw_en), .waddr(mw_addr), .wval(mw_val), .wnxt(mw_nxt),
		.wprv(mw_prv), .raddr(mr_addr), .rval(mr_val), .rnxt(mr_nxt), .rprv(mr_prv)
	);

	bdll_free_stack #(.DEPTH(CAPACITY), .PW(PW), .SW(SW)) u_free (
		.clk(clk), .arst_n(arst_n), .cmd(fs_cmd), .push_slot(cur_q[SW-1:0]),
		.pop_slot(pop_slot)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bdll_pkg::ST_IDLE: begin
				if (acc) begin
					if (is_ins && !full) begin
						state_d = bdll_pkg::ST_POP;
					end else if (is_walk && (32'(s_tdata[39:32]) < 32'(count_q))) begin
						state_d = bdll_pkg::ST_WALK;
					end else begin
						state_d = bdll_pkg::ST_RESP;
					end
				end
			end
			bdll_pkg::ST_POP: begin
				state_d = empty ? bdll_pkg::ST_RESP : bdll_pkg::ST_INS_LINK;
			end
			bdll_pkg::ST_INS_LINK: state_d = bdll_pkg::ST_RESP;
			bdll_pkg::ST_WALK: begin
				if (hit) begin
					state_d = (kind_q == bdll_pkg::KIND_READ) ? bdll_pkg::ST_RESP
						: bdll_pkg::ST_RM_PREV;
				end
			end
			bdll_pkg::ST_RM_PREV: state_d = bdll_pkg::ST_RM_NEXT;
			bdll_pkg::ST_RM_NEXT: state_d = bdll_pkg::ST_RESP;
			bdll_pkg::ST_RESP: begin
				if (out_free) begin
					state_d = bdll_pkg::ST_IDLE;
				end
			end
			default: state_d = bdll_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mw_en   = '0;
		mw_addr = '0;
		mw_nxt  = NIL;
		mw_prv  = NIL;
		fs_cmd  = '0;
		case (state_q)
			bdll_pkg::ST_IDLE: begin
				fs_cmd.pop   = acc && is_ins && !full;
				fs_cmd.clear = acc && (s_tuser == bdll_pkg::KIND_CLEAR);
			end
			bdll_pkg::ST_POP: begin
				mw_en   = '{val: 1'b1, nxt: 1'b1, prv: 1'b1};
				mw_addr = pop_slot;
				if (!empty && (kind_q == bdll_pkg::KIND_PREPEND)) begin
					mw_nxt = head_q;
				end
				if (!empty && (kind_q == bdll_pkg::KIND_APPEND)) begin
					mw_prv = tail_q;
				end
			end
			bdll_pkg::ST_INS_LINK: begin
				if (kind_q == bdll_pkg::KIND_APPEND) begin
					mw_en.nxt = 1'b1;
					mw_addr   = tail_q[SW-1:0];
					mw_nxt    = PW'(slot_q);
				end else begin
					mw_en.prv = 1'b1;
					mw_addr   = head_q[SW-1:0];
					mw_prv    = PW'(slot_q);
				end
			end
			bdll_pkg::ST_RM_PREV: begin
				fs_cmd.push = 1'b1;
				mw_en.nxt   = (prv_q != NIL);
				mw_addr     = prv_q[SW-1:0];
				mw_nxt      = nxt_q;
			end
			bdll_pkg::ST_RM_NEXT: begin
				mw_en.prv = (nxt_q != NIL);
				mw_addr   = nxt_q[SW-1:0];
				mw_prv    = prv_q;
			end
			default: begin
				mw_en = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bdll_pkg::ST_IDLE;
			head_q      <= NIL;
			tail_q      <= NIL;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= ((state_q == bdll_pkg::ST_RESP) && out_free)
				|| (out_valid_q && !m_tready);
			case (state_q)
				bdll_pkg::ST_IDLE: begin
					if (acc && (s_tuser == bdll_pkg::KIND_CLEAR)) begin
						head_q  <= NIL;
						tail_q  <= NIL;
						count_q <= '0;
					end
				end
				bdll_pkg::ST_POP: begin
					if (empty) begin
						head_q  <= PW'(pop_slot);
						tail_q  <= PW'(pop_slot);
						count_q <= count_q + PW'(1);
					end
				end
				bdll_pkg::ST_INS_LINK: begin
					if (kind_q == bdll_pkg::KIND_APPEND) begin
						tail_q <= PW'(slot_q);
					end else begin
						head_q <= PW'(slot_q);
					end
					count_q <= count_q + PW'(1);
				end
				bdll_pkg::ST_RM_PREV: begin
					if (prv_q == NIL) begin
						head_q <= nxt_q;
					end
				end
				bdll_pkg::ST_RM_NEXT: begin
					if (nxt_q == NIL) begin
						tail_q <= prv_q;
					end
					count_q <= count_q - PW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bdll_pkg::ST_IDLE: begin
				kind_q   <= s_tuser;
				val_q    <= s_tdata[31:0];
				pos_q    <= s_tdata[39:32];
				cnt_q    <= '0;
				cur_q    <= head_q;
				res_rd_q <= '0;
				if (is_ins && full) begin
					res_st_q <= bdll_pkg::STATUS_FULL;
				end else if (is_walk && (32'(s_tdata[39:32]) >= 32'(count_q))) begin
					res_st_q <= bdll_pkg::STATUS_INDEX;
				end else begin
					res_st_q <= bdll_pkg::STATUS_OK;
				end
			end
			bdll_pkg::ST_POP: slot_q <= pop_slot;
			bdll_pkg::ST_WALK: begin
				if (hit) begin
					res_rd_q <= (kind_q == bdll_pkg::KIND_READ) ? 32'(signed'(mr_val)) : '0;
					prv_q    <= mr_prv;
					nxt_q    <= mr_nxt;
				end else begin
					cnt_q <= cnt_q + 8'd1;
					cur_q <= mr_nxt;
				end
			end
			bdll_pkg::ST_RESP: begin
				if (out_free) begin
					out_rd_q  <= res_rd_q;
					out_st_q  <= res_st_q;
					out_len_q <= 9'(count_q);
				end
			end
			default: begin
				slot_q <= slot_q;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_len_q, out_rd_q};
	assign m_tuser  = out_st_q;

	`ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > NIL)
	`ASSERT_ON(a_head_empty, clk, arst_n,
		(state_q == bdll_pkg::ST_IDLE) |-> ((count_q == '0) == (head_q == NIL)))
	`ASSERT_ON(a_tail_empty, clk, arst_n,
		(state_q == bdll_pkg::ST_IDLE) |-> ((count_q == '0) == (tail_q == NIL)))
	`ASSERT_ON(a_walk_bound, clk, arst_n, (state_q == bdll_pkg::ST_WALK) |-> (cnt_q <= pos_q))

endmodule

// File: dv/bounded_doubly_linked_list_tb.sv
// Testbench for bounded_doubly_linked_list: directed table, fill to capacity, then random list operations.
// Checks every result against its table row or an in-bench list model; depends on bdll_pkg and the RTL.
module bounded_doubly_linked_list_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = 256;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] value;
		logic [7:0]  position;
	} list_req_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic [8:0]  list_length;
		logic [1:0]  status;
	} list_rsp_t;

	typedef struct {
		list_req_t req;
		bit        typed;
		list_rsp_t rsp;
	} table_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;

	bounded_doubly_linked_list dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	logic [31:0] list_vals[$];
	list_rsp_t   pending_rsp[$];
	int          mismatches = 0;
	bit          idle_free;

	function automatic list_rsp_t apply_list_op(list_req_t r);
		list_rsp_t o;
		o.read_value = '0;
		o.status = bdll_pkg::STATUS_OK;
		case (r.kind)
			bdll_pkg::KIND_APPEND, bdll_pkg::KIND_PREPEND: begin
				if (list_vals.size() >= CAP) o.status = bdll_pkg::STATUS_FULL;
				else if (r.kind == bdll_pkg::KIND_APPEND) list_vals.push_back(r.value);
				else list_vals.push_front(r.value);
			end
			bdll_pkg::KIND_REMOVE, bdll_pkg::KIND_READ: begin
				if (r.position >= list_vals.size()) o.status = bdll_pkg::STATUS_INDEX;
				else if (r.kind == bdll_pkg::KIND_READ) o.read_value = list_vals[r.position];
				else list_vals.delete(r.position);
			end
			bdll_pkg::KIND_CLEAR: list_vals.delete();
			default: ;
		endcase
		o.list_length = 9'(list_vals.size());
		return o;
	endfunction

	task automatic send_request(list_req_t r, bit typed, list_rsp_t t);
		list_rsp_t p;
		while (!idle_free && $urandom_range(99) < 26) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		p = apply_list_op(r);
		if (typed && p != t)
			$display("table row disagrees with list model: kind %0d", r.kind);
		pending_rsp.push_back(typed ? t : p);
		s_tvalid <= 1'b1;
		s_tuser <= r.kind;
		s_tdata <= {r.position, r.value};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("CHECKS FAILED");
		$finish;
	end

	always @(negedge clk) begin
		m_tready <= (idle_free || $urandom_range(99) >= 26);
	end

	always @(posedge clk) begin
		list_rsp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h/%0d", m_tdata, m_tuser);
			end else begin
				want = pending_rsp.pop_front();
				if (m_tdata[31:0] !== want.read_value || m_tdata[40:32] !== want.list_length
						|| m_tdata[47:41] !== 7'd0 || m_tuser !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp val %h len %0d st %0d, got val %h len %0d st %0d",
							want.read_value, want.list_length, want.status,
							m_tdata[31:0], m_tdata[40:32], m_tuser);
				end
			end
		end
	end

	initial begin
		table_row_t rows[$];
		table_row_t row;
		list_req_t  rq;
		list_rsp_t  none;
		int         n;
		int         pick;
		int         waits;
		idle_free = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = bdll_pkg::KIND_APPEND;
		none = '{32'd0, 9'd0, bdll_pkg::STATUS_OK};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		rows = '{
			'{'{bdll_pkg::KIND_READ, 32'd0, 8'd0}, 1,
				'{32'd0, 9'd0, bdll_pkg::STATUS_INDEX}},
			'{'{bdll_pkg::KIND_REMOVE, 32'd0, 8'd255}, 1,
				'{32'd0, 9'd0, bdll_pkg::STATUS_INDEX}},
			'{'{bdll_pkg::KIND_APPEND, 32'h7fffffff, 8'd0}, 1,
				'{32'd0, 9'd1, bdll_pkg::STATUS_OK}},
			'{'{bdll_pkg::KIND_PREPEND, 32'h80000000, 8'd0}, 1,
				'{32'd0, 9'd2, bdll_pkg::STATUS_OK}},
			'{'{bdll_pkg::KIND_APPEND, 32'hffffffff, 8'hff}, 1,
				'{32'd0, 9'd3, bdll_pkg::STATUS_OK}},
			'{'{bdll_pkg::KIND_READ, 32'd0, 8'd0}, 1,
				'{32'h80000000, 9'd3, bdll_pkg::STATUS_OK}},
			'{'{bdll_pkg::KIND_READ, 32'hffffffff, 8'd2}, 1,
				'{32'hffffffff, 9'd3, bdll_pkg::STATUS_OK}},
			'{'{bdll_pkg::KIND_READ, 32'd0, 8'd3}, 1,
				'{32'd0, 9'd3, bdll_pkg::STATUS_INDEX}},
			'{'{3'd5, 32'h12345678, 8'd1}, 1, '{32'd0, 9'd3, bdll_pkg::STATUS_OK}},
			'{'{3'd6, 32'd0, 8'd0}, 1, '{32'd0, 9'd3, bdll_pkg::STATUS_OK}},
			'{'{3'd7, 32'd0, 8'd0}, 1, '{32'd0, 9'd3, bdll_pkg::STATUS_OK}},
			'{'{bdll_pkg::KIND_REMOVE, 32'd0, 8'd0}, 0, none},
			'{'{bdll_pkg::KIND_REMOVE, 32'd0, 8'd1}, 0, none},
			'{'{bdll_pkg::KIND_READ, 32'd0, 8'd0}, 0, none},
			'{'{bdll_pkg::KIND_PREPEND, 32'd5, 8'd0}, 0, none},
			'{'{bdll_pkg::KIND_REMOVE, 32'd0, 8'd1}, 0, none},
			'{'{bdll_pkg::KIND_REMOVE, 32'd0, 8'd0}, 1,
				'{32'd0, 9'd0, bdll_pkg::STATUS_OK}},
			'{'{bdll_pkg::KIND_APPEND, 32'd9, 8'd0}, 0, none},
			'{'{bdll_pkg::KIND_CLEAR, 32'd0, 8'd0}, 1,
				'{32'd0, 9'd0, bdll_pkg::STATUS_OK}}
		};
		foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].rsp);

		// fill to capacity, overflow both ends, probe deep positions
		for (int i = 0; i < CAP; i++)
			send_request('{bdll_pkg::KIND_APPEND, $urandom, 8'($urandom)}, 0, none);
		send_request('{bdll_pkg::KIND_APPEND, 32'd1, 8'd0}, 1,
			'{32'd0, 9'd256, bdll_pkg::STATUS_FULL});
		send_request('{bdll_pkg::KIND_PREPEND, 32'd2, 8'd0}, 1,
			'{32'd0, 9'd256, bdll_pkg::STATUS_FULL});
		send_request('{bdll_pkg::KIND_READ, 32'd0, 8'd255}, 0, none);
		send_request('{bdll_pkg::KIND_REMOVE, 32'd0, 8'd255}, 0, none);
		send_request('{bdll_pkg::KIND_REMOVE, 32'd0, 8'd128}, 0, none);
		send_request('{bdll_pkg::KIND_PREPEND, 32'd3, 8'd0}, 0, none);
		send_request('{bdll_pkg::KIND_READ, 32'd0, 8'd0}, 0, none);
		s_tvalid <= 1'b0;

		waits = 0;
		while (pending_rsp.size() != 0 && waits < 100000) begin
			@(negedge clk);
			waits++;
		end

		for (n = 0; n < 818; n++) begin
			idle_free = (n >= 300 && n < 450);
			rq.value = $urandom;
			pick = $urandom_range(99);
			if (list_vals.size() < 20) pick = pick % 60;
			if (pick < 30) rq.kind = bdll_pkg::KIND_APPEND;
			else if (pick < 50) rq.kind = bdll_pkg::KIND_PREPEND;
			else if (pick < 70) rq.kind = bdll_pkg::KIND_READ;
			else if (pick < 94) rq.kind = bdll_pkg::KIND_REMOVE;
			else if (pick < 97) rq.kind = bdll_pkg::KIND_CLEAR;
			else rq.kind = 3'($urandom_range(5, 7));
			if ($urandom_range(9) == 0 || list_vals.size() == 0) rq.position = 8'($urandom);
			else rq.position = 8'($urandom_range(list_vals.size() - 1));
			send_request(rq, 0, none);
		end
		idle_free = 1'b0;
		s_tvalid <= 1'b0;

		waits = 0;
		while (pending_rsp.size() != 0 && waits < 1000000) begin
			@(negedge clk);
			waits++;
		end
		repeat (300) @(negedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
